// ===== hw/rtl/dvh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Distinct value histogram package
// Shared sizes, control structs and the saturating increment used by the
// histogram core and its cell row.
// ----------------------------------------------------------------------------
package dvh_pkg;

  // Number of nonzero bins, one cell per bin.
  localparam int unsigned MAX_BINS    = 64;
  // Field widths fixed by the item format.
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned COUNT_W     = 32;
  localparam int unsigned BIN_INDEX_W = 7;
  // Internal bin index width, wide enough for MAX_BINS itself.
  localparam int unsigned IDX_W       = $clog2(MAX_BINS + 1);
  // Result gathering: cells are ORed in groups, group results are registered.
  localparam int unsigned GROUP_SIZE  = 8;
  localparam int unsigned NUM_GROUPS  = (MAX_BINS + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int unsigned PAD_BINS    = NUM_GROUPS * GROUP_SIZE;

  localparam logic [COUNT_W-1:0] COUNT_TOP = '1;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic cmp;  // compare the sample against every stored value
    logic upd;  // apply the update for a nonzero sample
  } ctrl_t;

  // Status returned by the cell row.
  typedef struct packed {
    logic any_hit;    // some cell holds the sample value
    logic last_used;  // the last cell is taken, so the table is full
  } row_stat_t;

  // Count increment that sticks at the top of its range.
  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] cnt);
    logic [COUNT_W-1:0] res;
    res = (cnt == COUNT_TOP) ? cnt : cnt + COUNT_W'(1);
    return res;
  endfunction

endpackage

// ===== hw/rtl/dvh_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Histogram bin cell
// Holds one distinct value and its count. Compares the broadcast sample,
// claims itself when it is the first free bin, and passes its in-use flag
// to the next cell of the row.
// ----------------------------------------------------------------------------
module dvh_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dvh_pkg::ctrl_t              ctrl_i,
  input  logic [dvh_pkg::VALUE_W-1:0] sample_i,
  input  logic                        prev_used_i,
  input  logic                        any_hit_i,
  output logic                        used_o,
  output logic                        hit_o,
  output logic                        sel_o,
  output logic [dvh_pkg::COUNT_W-1:0] count_o
);

  logic                        used_q;
  logic                        hit_q;
  logic [dvh_pkg::VALUE_W-1:0] value_q;
  logic [dvh_pkg::COUNT_W-1:0] count_q;
  logic                        claim;
  logic [dvh_pkg::COUNT_W-1:0] count_d;

  // The first free cell takes a value that no cell holds.
  assign claim   = ctrl_i.upd && !any_hit_i && prev_used_i && !used_q;
  assign sel_o   = claim || (ctrl_i.upd && hit_q);
  assign count_d = claim ? dvh_pkg::COUNT_W'(1) : dvh_pkg::sat_inc(count_q);

  // Control flags of the cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
      hit_q  <= 1'b0;
    end else begin
      if (ctrl_i.cmp) begin
        hit_q <= used_q && (value_q == sample_i);
      end
      if (claim) begin
        used_q <= 1'b1;
      end
    end
  end

  // Stored value and count; only read once the cell is in use.
  always_ff @(posedge clk_i) begin
    if (claim) begin
      value_q <= sample_i;
    end
    if (sel_o) begin
      count_q <= count_d;
    end
  end

  assign used_o  = used_q;
  assign hit_o   = hit_q;
  assign count_o = count_d;

endmodule

// ===== hw/rtl/dvh_row.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Histogram cell row
// Chains the bin cells through their in-use flags and gathers the index and
// new count of the updated cell through a registered two-level OR tree.
// ----------------------------------------------------------------------------
module dvh_row (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dvh_pkg::ctrl_t              ctrl_i,
  input  logic [dvh_pkg::VALUE_W-1:0] sample_i,
  output dvh_pkg::row_stat_t          stat_o,
  output logic [dvh_pkg::IDX_W-1:0]   sel_idx_o,
  output logic [dvh_pkg::COUNT_W-1:0] sel_count_o
);

  logic [dvh_pkg::MAX_BINS-1:0] used;
  logic [dvh_pkg::MAX_BINS-1:0] hit;
  logic [dvh_pkg::MAX_BINS-1:0] sel;
  logic                         any_hit;

  logic [dvh_pkg::IDX_W-1:0]   pad_idx [dvh_pkg::PAD_BINS];
  logic [dvh_pkg::COUNT_W-1:0] pad_cnt [dvh_pkg::PAD_BINS];
  logic [dvh_pkg::IDX_W-1:0]   grp_idx_d [dvh_pkg::NUM_GROUPS];
  logic [dvh_pkg::COUNT_W-1:0] grp_cnt_d [dvh_pkg::NUM_GROUPS];
  logic [dvh_pkg::IDX_W-1:0]   grp_idx_q [dvh_pkg::NUM_GROUPS];
  logic [dvh_pkg::COUNT_W-1:0] grp_cnt_q [dvh_pkg::NUM_GROUPS];

  assign any_hit = |hit;

  // Row of cells; cell k holds bin k+1 and sees the in-use flag of cell k-1.
  for (genvar i = 0; i < dvh_pkg::PAD_BINS; i++) begin : g_cell
    if (i < dvh_pkg::MAX_BINS) begin : g_real
      logic                        prev_used;
      logic [dvh_pkg::COUNT_W-1:0] cnt;

      if (i == 0) begin : g_first
        assign prev_used = 1'b1;
      end else begin : g_next
        assign prev_used = used[i-1];
      end

      dvh_cell u_cell (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .ctrl_i      (ctrl_i),
        .sample_i    (sample_i),
        .prev_used_i (prev_used),
        .any_hit_i   (any_hit),
        .used_o      (used[i]),
        .hit_o       (hit[i]),
        .sel_o       (sel[i]),
        .count_o     (cnt)
      );

      // Only the selected cell drives the gather tree.
      assign pad_idx[i] = sel[i] ? dvh_pkg::IDX_W'(i + 1) : '0;
      assign pad_cnt[i] = sel[i] ? cnt : '0;
    end else begin : g_pad
      assign pad_idx[i] = '0;
      assign pad_cnt[i] = '0;
    end
  end

  // First level of the gather tree, one OR per group.
  for (genvar g = 0; g < dvh_pkg::NUM_GROUPS; g++) begin : g_grp
    always_comb begin
      grp_idx_d[g] = '0;
      grp_cnt_d[g] = '0;
      for (int j = 0; j < dvh_pkg::GROUP_SIZE; j++) begin
        grp_idx_d[g] = grp_idx_d[g] | pad_idx[g * dvh_pkg::GROUP_SIZE + j];
        grp_cnt_d[g] = grp_cnt_d[g] | pad_cnt[g * dvh_pkg::GROUP_SIZE + j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctrl_i.upd) begin
        grp_idx_q[g] <= grp_idx_d[g];
        grp_cnt_q[g] <= grp_cnt_d[g];
      end
    end
  end

  // Second level of the gather tree over the registered groups.
  always_comb begin
    sel_idx_o   = '0;
    sel_count_o = '0;
    for (int g = 0; g < dvh_pkg::NUM_GROUPS; g++) begin
      sel_idx_o   = sel_idx_o | grp_idx_q[g];
      sel_count_o = sel_count_o | grp_cnt_q[g];
    end
  end

  assign stat_o.any_hit   = any_hit;
  assign stat_o.last_used = used[dvh_pkg::MAX_BINS-1];

endmodule

// ===== hw/rtl/distinct_value_histogram_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Distinct value histogram core
// Counts how often each distinct value occurs. Zero counts in bin 0, other
// values match a stored bin or open the next free one in a row of cells.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake             | Payload
//  --------+-----------+-----------------------+---------------------------------
//  in      | input     | in_valid_i/in_stall_o | sample_value_i
//  out     | output    | out_valid_o/out_stall_i | bin_index_o, bin_count_o,
//          |           |                       | new_bin_o, table_full_o
//
//  An item passes through capture, compare in all cells, update and
//  gather, with the result loaded into the output register at the end.
//  The next item is taken in the cycle that loads the previous result.
//  Compare and update run in the cell row, and the result comes through
//  its two-level gather tree. Reset clears the zero-bin count and all
//  in-use flags. A stalled result holds the last step until the output
//  register frees up.
// ----------------------------------------------------------------------------
module distinct_value_histogram_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [dvh_pkg::VALUE_W-1:0]     sample_value_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [dvh_pkg::BIN_INDEX_W-1:0] bin_index_o,
  output logic [dvh_pkg::COUNT_W-1:0]     bin_count_o,
  output logic                            new_bin_o,
  output logic                            table_full_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CMP  = 4'b0010,
    S_UPD  = 4'b0100,
    S_GATH = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [dvh_pkg::VALUE_W-1:0]     sample_q;
  logic                            zero_q;
  logic                            new_q;
  logic                            full_q;
  logic [dvh_pkg::COUNT_W-1:0]     zero_cnt_q;
  logic                            out_valid_q;
  logic [dvh_pkg::BIN_INDEX_W-1:0] out_idx_q;
  logic [dvh_pkg::COUNT_W-1:0]     out_cnt_q;
  logic                            out_new_q;
  logic                            out_full_q;

  logic                            in_accept;
  logic                            out_load;
  dvh_pkg::ctrl_t                  ctrl;
  dvh_pkg::row_stat_t              row_stat;
  logic [dvh_pkg::IDX_W-1:0]       row_idx;
  logic [dvh_pkg::COUNT_W-1:0]     row_cnt;

  // Handshake: a result loads when the output register is empty or draining.
  assign out_load   = (state_q == S_GATH) && (!out_valid_q || !out_stall_i);
  assign in_stall_o = !((state_q == S_IDLE) || out_load);
  assign in_accept  = in_valid_i && !in_stall_o;

  // Cell control; zero samples are compared but never update the cells.
  assign ctrl.cmp = (state_q == S_CMP);
  assign ctrl.upd = (state_q == S_UPD) && !zero_q;

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        state_d = S_UPD;
      end
      S_UPD: begin
        state_d = S_GATH;
      end
      S_GATH: begin
        if (out_load) begin
          state_d = in_accept ? S_CMP : S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Row of bin cells.
  dvh_row u_row (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .sample_i    (sample_q),
    .stat_o      (row_stat),
    .sel_idx_o   (row_idx),
    .sel_count_o (row_cnt)
  );

  // Sample capture and outcome flags of the current transaction.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      sample_q <= sample_value_i;
      zero_q   <= (sample_value_i == '0);
    end
    if (state_q == S_UPD) begin
      new_q  <= !zero_q && !row_stat.any_hit && !row_stat.last_used;
      full_q <= !zero_q && !row_stat.any_hit && row_stat.last_used;
    end
  end

  // Zero-bin count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_cnt_q <= '0;
    end else if ((state_q == S_UPD) && zero_q) begin
      zero_cnt_q <= dvh_pkg::sat_inc(zero_cnt_q);
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_idx_q  <= zero_q ? '0 : dvh_pkg::BIN_INDEX_W'(row_idx);
      out_cnt_q  <= zero_q ? zero_cnt_q : row_cnt;
      out_new_q  <= new_q;
      out_full_q <= full_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign bin_index_o  = out_idx_q;
  assign bin_count_o  = out_cnt_q;
  assign new_bin_o    = out_new_q;
  assign table_full_o = out_full_q;

endmodule

// ===== hw/rtl/dvh_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Distinct value histogram checker
// Port-level checks on the histogram core, attached by a bind statement.
// ----------------------------------------------------------------------------
module dvh_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic [dvh_pkg::BIN_INDEX_W-1:0] bin_index_o,
  input logic [dvh_pkg::COUNT_W-1:0]     bin_count_o,
  input logic                            new_bin_o,
  input logic                            table_full_o
);

  // A stalled result transaction keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(bin_index_o)
      && $stable(bin_count_o) && $stable(new_bin_o) && $stable(table_full_o))
    else $error("stalled result changed");

  // A dropped value reports bin 0 with count 0 and opens nothing.
  a_full_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && table_full_o |-> !new_bin_o && (bin_index_o == '0)
      && (bin_count_o == '0))
    else $error("table-full result is not empty");

  // A newly opened bin is a nonzero bin with count one.
  a_new_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && new_bin_o |-> (bin_index_o != '0) && (bin_count_o == 32'd1))
    else $error("new bin result has wrong index or count");

  // A rising result valid traces back to an accepted input transaction
  // through the compare, update and gather states.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 4))
    else $error("result without matching input transaction");

endmodule

bind distinct_value_histogram_core dvh_checker u_dvh_checker (.*);
